// File: src/memory_with_watch_zones_core_macros.svh
`ifndef MEMORY_WITH_WATCH_ZONES_CORE_MACROS_SVH
`define MEMORY_WITH_WATCH_ZONES_CORE_MACROS_SVH

// same-cycle implication, held off while reset is low
`define MWZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("memory_with_watch_zones_core: assertion failed");

// next-cycle implication, held off while reset is low
`define MWZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("memory_with_watch_zones_core: assertion failed");

`endif

// File: src/mwz_pkg.sv
`timescale 1ns / 1ps

package mwz_pkg;

    localparam int MEM_BYTES_DEF  = 65536;
    localparam int ZONE_SLOTS_DEF = 8;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 64;
    localparam int LEN_W  = 17;
    localparam int ID_W   = 16;
    localparam int HIT_W  = 8;
    localparam int EV_W   = 3;

    localparam int EV_READ_BIT  = 0;
    localparam int EV_WRITE_BIT = 1;
    localparam int EV_PRE_BIT   = 2;

    localparam logic [ID_W-1:0] FIRST_ID = ID_W'(1);

    typedef enum logic [2:0] {
        OP_RD_BYTE  = 3'd0,
        OP_RD_WORD  = 3'd1,
        OP_RD_DWORD = 3'd2,
        OP_WR_BYTE  = 3'd3,
        OP_WR_WORD  = 3'd4,
        OP_WR_DWORD = 3'd5,
        OP_ADD_ZONE = 3'd6,
        OP_RM_ZONE  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ZERO    = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  write_data;
        logic [LEN_W-1:0]   zone_length;
        logic [EV_W-1:0]    event_mask;
        logic [ID_W-1:0]    zone_id;
    } t_req_item;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [HIT_W-1:0]   pre_read_hits;
        logic [HIT_W-1:0]   access_hits;
        logic [ID_W-1:0]    new_zone_id;
        t_status            status;
    } t_rsp_item;

endpackage

// File: src/mwz_chan_if.sv
`timescale 1ns / 1ps

interface mwz_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/mwz_ram.sv
`timescale 1ns / 1ps

module mwz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mwz_pkg::MEM_BYTES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/memory_with_watch_zones_core.sv
`timescale 1ns / 1ps

// Byte memory with a table of watch zones. Every request transfer gives one response
// transfer. After reset the memory is swept to zero, one byte per cycle, and no request
// is taken until that sweep ends. The memory is a single byte-wide port with a registered
// read, so a byte, word or dword read or write goes through it one byte at a time; zone
// add, zone remove and out-of-range accesses do not touch the memory. Zone hits are
// matched against the start address only, in the cycle the request is taken.

`include "memory_with_watch_zones_core_macros.svh"

module memory_with_watch_zones_core #(
    parameter int MEM_BYTES  = mwz_pkg::MEM_BYTES_DEF,
    parameter int ZONE_SLOTS = mwz_pkg::ZONE_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mwz_chan_if.sink   i_req,
    mwz_chan_if.source o_rsp
);

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int EW = ((AW + 1) > (mwz_pkg::ADDR_W + 1)) ? (AW + 1) : (mwz_pkg::ADDR_W + 1);
    localparam int SW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
    localparam int HW = (ZONE_SLOTS > mwz_pkg::HIT_W) ? ZONE_SLOTS : mwz_pkg::HIT_W;
    localparam int ZW = mwz_pkg::LEN_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_RLAST,
        S_WRITE,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic [AW-1:0]                  r_clr;
    logic [mwz_pkg::ADDR_W-1:0]     r_addr;
    logic [2:0]                     r_cnt;
    logic [2:0]                     r_last;
    logic                           r_pend;
    logic [mwz_pkg::DATA_W-1:0]     r_wdata;
    logic [mwz_pkg::DATA_W-1:0]     r_rdata;
    logic                           r_res_rd;
    logic [mwz_pkg::HIT_W-1:0]      r_res_pre;
    logic [mwz_pkg::HIT_W-1:0]      r_res_acc;
    logic [mwz_pkg::ID_W-1:0]       r_res_id;
    mwz_pkg::t_status               r_res_status;
    logic                           r_out_valid;
    mwz_pkg::t_rsp_item             r_out;
    logic [mwz_pkg::ID_W-1:0]       r_next_id;

    logic [ZONE_SLOTS-1:0]          r_zone_valid;
    logic [mwz_pkg::ADDR_W-1:0]     r_zone_base  [ZONE_SLOTS];
    logic [mwz_pkg::LEN_W-1:0]      r_zone_size  [ZONE_SLOTS];
    logic [mwz_pkg::EV_W-1:0]       r_zone_ev    [ZONE_SLOTS];
    logic [mwz_pkg::ID_W-1:0]       r_zone_ident [ZONE_SLOTS];

    mwz_pkg::t_req_item             req;
    logic                           accept;
    logic                           is_access;
    logic                           is_read;
    logic [2:0]                     last_idx;
    logic                           range_err;
    logic [ZONE_SLOTS-1:0]          zone_in;
    logic [ZONE_SLOTS-1:0]          zone_pre;
    logic [ZONE_SLOTS-1:0]          zone_rd;
    logic [ZONE_SLOTS-1:0]          zone_wr;
    logic [HW-1:0]                  pre_pad;
    logic [HW-1:0]                  acc_pad;
    logic                           free_found;
    logic [SW-1:0]                  free_idx;
    logic                           id_found;
    logic [SW-1:0]                  id_idx;
    logic [mwz_pkg::ID_W-1:0]       n_next_id;
    t_state                         n_state;
    logic                           n_res_rd;
    logic [mwz_pkg::HIT_W-1:0]      n_res_pre;
    logic [mwz_pkg::HIT_W-1:0]      n_res_acc;
    logic [mwz_pkg::ID_W-1:0]       n_res_id;
    mwz_pkg::t_status               n_res_status;
    logic                           zone_add;
    logic                           zone_rm;
    logic [EW-1:0]                  byte_sum;
    logic                           ram_we;
    logic [AW-1:0]                  ram_addr;
    logic [7:0]                     ram_wdata;
    logic [7:0]                     ram_rdata;
    logic [mwz_pkg::DATA_W-1:0]     rd_aligned;
    logic                           in_bytes;
    logic                           out_err;
    logic                           out_clean;

    assign req    = i_req.data;
    assign accept = i_req.valid && i_req.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // request decode
    always_comb begin
        is_access = 1'b1;
        is_read   = 1'b0;
        last_idx  = 3'd0;
        unique case (req.operation) inside
            mwz_pkg::OP_RD_BYTE: begin
                is_read = 1'b1;
            end
            mwz_pkg::OP_RD_WORD: begin
                is_read  = 1'b1;
                last_idx = 3'd3;
            end
            mwz_pkg::OP_RD_DWORD: begin
                is_read  = 1'b1;
                last_idx = 3'd7;
            end
            mwz_pkg::OP_WR_BYTE: begin
                last_idx = 3'd0;
            end
            mwz_pkg::OP_WR_WORD: begin
                last_idx = 3'd3;
            end
            mwz_pkg::OP_WR_DWORD: begin
                last_idx = 3'd7;
            end
            mwz_pkg::OP_ADD_ZONE, mwz_pkg::OP_RM_ZONE: begin
                is_access = 1'b0;
            end
            default: begin
                is_access = 1'b0;
            end
        endcase
    end

    assign range_err = (EW'(req.address) + EW'(last_idx)) >= EW'(MEM_BYTES);

    // zone match against the request address
    always_comb begin
        for (int s = 0; s < ZONE_SLOTS; s++) begin
            zone_in[s] = r_zone_valid[s]
                && (r_zone_base[s] <= req.address)
                && (ZW'(req.address) < (ZW'(r_zone_base[s]) + ZW'(r_zone_size[s])));
            zone_pre[s] = zone_in[s] && r_zone_ev[s][mwz_pkg::EV_PRE_BIT];
            zone_rd[s]  = zone_in[s] && r_zone_ev[s][mwz_pkg::EV_READ_BIT];
            zone_wr[s]  = zone_in[s] && r_zone_ev[s][mwz_pkg::EV_WRITE_BIT];
        end
    end

    assign pre_pad = HW'(zone_pre);
    assign acc_pad = is_read ? HW'(zone_rd) : HW'(zone_wr);

    // lowest free slot and lowest slot holding the id
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        id_found   = 1'b0;
        id_idx     = '0;
        for (int s = ZONE_SLOTS - 1; s >= 0; s--) begin
            if (!r_zone_valid[s]) begin
                free_found = 1'b1;
                free_idx   = SW'(s);
            end
            if (r_zone_valid[s] && (r_zone_ident[s] == req.zone_id)) begin
                id_found = 1'b1;
                id_idx   = SW'(s);
            end
        end
    end

    always_comb begin
        n_next_id = r_next_id + mwz_pkg::FIRST_ID;
        if (n_next_id == '0) begin
            n_next_id = mwz_pkg::FIRST_ID;
        end
    end

    // outcome of the request on offer
    always_comb begin
        n_state      = S_DONE;
        n_res_rd     = 1'b0;
        n_res_pre    = '0;
        n_res_acc    = '0;
        n_res_id     = '0;
        n_res_status = mwz_pkg::ST_OK;
        zone_add     = 1'b0;
        zone_rm      = 1'b0;
        if (is_access) begin
            if (range_err) begin
                n_res_status = mwz_pkg::ST_RANGE;
            end else begin
                n_res_acc = acc_pad[mwz_pkg::HIT_W-1:0];
                if (is_read) begin
                    n_res_rd  = 1'b1;
                    n_res_pre = pre_pad[mwz_pkg::HIT_W-1:0];
                    n_state   = S_READ;
                end else begin
                    n_state = S_WRITE;
                end
            end
        end else if (req.operation == mwz_pkg::OP_ADD_ZONE) begin
            if (req.zone_length == '0) begin
                n_res_status = mwz_pkg::ST_ZERO;
            end else if (!free_found) begin
                n_res_status = mwz_pkg::ST_FULL;
            end else begin
                zone_add = 1'b1;
                n_res_id = r_next_id;
            end
        end else if (id_found) begin
            zone_rm = 1'b1;
        end else begin
            n_res_status = mwz_pkg::ST_UNKNOWN;
        end
    end

    // memory port
    assign byte_sum = EW'(r_addr) + EW'(r_cnt);

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = byte_sum[AW-1:0];
        ram_wdata = r_wdata[7:0];
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            S_IDLE, S_READ, S_RLAST, S_DONE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    mwz_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // bytes shift in from the top, so align by size at the end
    always_comb begin
        case (r_last)
            3'd0:    rd_aligned = {56'd0, r_rdata[63:56]};
            3'd3:    rd_aligned = {32'd0, r_rdata[63:32]};
            default: rd_aligned = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_zone_valid <= '0;
            r_next_id    <= mwz_pkg::FIRST_ID;
        end else begin
            if (r_pend) begin
                r_rdata <= {ram_rdata, r_rdata[63:8]};
            end
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MEM_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_addr       <= req.address;
                        r_wdata      <= req.write_data;
                        r_last       <= last_idx;
                        r_cnt        <= '0;
                        r_res_rd     <= n_res_rd;
                        r_res_pre    <= n_res_pre;
                        r_res_acc    <= n_res_acc;
                        r_res_id     <= n_res_id;
                        r_res_status <= n_res_status;
                        r_state      <= n_state;
                        if (zone_add) begin
                            r_zone_valid[free_idx] <= 1'b1;
                            r_zone_base[free_idx]  <= req.address;
                            r_zone_size[free_idx]  <= req.zone_length;
                            r_zone_ev[free_idx]    <= req.event_mask;
                            r_zone_ident[free_idx] <= r_next_id;
                            r_next_id              <= n_next_id;
                        end
                        if (zone_rm) begin
                            r_zone_valid[id_idx] <= 1'b0;
                        end
                    end
                end
                S_READ: begin
                    r_pend <= 1'b1;
                    if (r_cnt == r_last) begin
                        r_state <= S_RLAST;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_RLAST: begin
                    r_pend  <= 1'b0;
                    r_state <= S_DONE;
                end
                S_WRITE: begin
                    r_wdata <= {8'd0, r_wdata[63:8]};
                    if (r_cnt == r_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid         <= 1'b1;
                        r_out.read_data     <= r_res_rd ? rd_aligned : '0;
                        r_out.pre_read_hits <= r_res_pre;
                        r_out.access_hits   <= r_res_acc;
                        r_out.new_zone_id   <= r_res_id;
                        r_out.status        <= r_res_status;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign in_bytes  = (r_state == S_READ) || (r_state == S_WRITE);
    assign out_err   = r_out_valid && (r_out.status != mwz_pkg::ST_OK);
    assign out_clean = (r_out.read_data == '0) && (r_out.pre_read_hits == '0)
        && (r_out.access_hits == '0);

    `MWZ_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `MWZ_ASSERT_IMP(a_byte_count_bound, i_clk, i_rst_n, in_bytes, r_cnt <= r_last)
    `MWZ_ASSERT_IMP(a_last_byte_pending, i_clk, i_rst_n, r_state == S_RLAST, r_pend)
    `MWZ_ASSERT_IMP(a_id_never_zero, i_clk, i_rst_n, r_next_id == '0, 1'b0)
    `MWZ_ASSERT_IMP(a_error_no_data, i_clk, i_rst_n, out_err, out_clean)

endmodule
